@@ src/angle_sensor_response_checker_defines.svh @@
// Assertion macros for the angle sensor response checker.
`ifndef ANGLE_SENSOR_RESPONSE_CHECKER_DEFINES_SVH
`define ANGLE_SENSOR_RESPONSE_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define ASRC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asrc assertion failed");

// Next-cycle implication.
`define ASRC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asrc assertion failed");

// Delayed implication.
`define ASRC_ASSERT_DLY2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("asrc assertion failed");

`endif

@@ src/asrc_pkg.sv @@
// Types, constants and check functions of the angle sensor response checker.
`default_nettype none

package asrc_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned WIN_W      = 64;
   localparam int unsigned WIN_BYTES  = WIN_W / 8;
   localparam int unsigned MISS_W     = 6;
   localparam int unsigned CODE_W     = 8;
   localparam int unsigned PAY_W      = 16;
   localparam int unsigned KIND_W     = 3;
   localparam int unsigned SHIFT_W    = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [7:0] wbyte_type;

   typedef struct packed {
      logic [CODE_W-1:0] time_code;
      logic [PAY_W-1:0]  payload;
   } record_type;

   localparam logic [CODE_W-1:0] ERR_CODE = 8'hFF;

   localparam logic [PAY_W-1:0] ERR_OVERFLOW  = 16'd0;
   localparam logic [PAY_W-1:0] ERR_SCHEDULE  = 16'd1;
   localparam logic [PAY_W-1:0] ERR_XFER_TIME = 16'd2;
   localparam logic [PAY_W-1:0] ERR_CRC       = 16'd3;
   localparam logic [PAY_W-1:0] ERR_DUP       = 16'd4;
   localparam logic [PAY_W-1:0] ERR_NO_ANGLE  = 16'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_CHIP_KIND     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_AMOUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_XFER_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH_AGE_LIM = 3'd3;

   localparam logic [KIND_W-1:0] KIND_FLAG_BIT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PARITY_A = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CRC_1D   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PARITY_B = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CRC_07   = 3'd4;

   localparam logic [TIME_W-1:0] XFER_LIMIT_RST = 32'd3600;
   localparam logic [TIME_W-1:0] LATCH_AGE_RST  = 32'd98304;

   localparam wbyte_type POLY_1D = 8'h1D;
   localparam wbyte_type INIT_1D = 8'h05;
   localparam wbyte_type POLY_07 = 8'h07;
   localparam wbyte_type INIT_07 = 8'h00;

   // One byte of an MSB-first CRC8.
   function automatic wbyte_type crc8_byte(input wbyte_type crc, input wbyte_type data,
                                           input wbyte_type poly);
      wbyte_type c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/angle_sensor_response_checker.sv @@
// Angle sensor response checker: decodes one sensor transfer into error and angle records.
//
// Input item: start with the req_ ports (response window, scheduled, start and end ticks,
// missed ticks); taken at an edge where start is high and busy is low.
// Records leave on rsp_time_code / rsp_payload / rsp_last_record, marked by rsp_valid
// for one cycle each; the receiver cannot stall, so none are ever held.
// Per item: one overflow record for each missed tick, then the checked record (angle,
// or time code 255 with an error number). rsp_last_record marks the final one.
// An accepted item is held in registers; its records leave one per cycle through the
// single result register. With no missed ticks an item may start every cycle.
// busy is high while overflow records of the held item are still to go.
// Chip kinds 5..7 give only the overflow records.
// Registers (csr_): chip kind, rounding shift, transfer time limit, latch age limit;
// write only while no item is in flight.
// Reset: synchronous; registers return to their defaults, any item in flight is dropped.
`default_nettype none

`include "angle_sensor_response_checker_defines.svh"

module angle_sensor_response_checker #(
   parameter int unsigned TIMESTAMP_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [asrc_pkg::WIN_W-1:0]           req_response_window,
   input  wire logic [asrc_pkg::TIME_W-1:0]          req_scheduled_time,
   input  wire logic [asrc_pkg::TIME_W-1:0]          req_start_time,
   input  wire logic [asrc_pkg::TIME_W-1:0]          req_end_time,
   input  wire logic [asrc_pkg::MISS_W-1:0]          req_missed_ticks,
   output logic                                      rsp_valid,
   output logic [asrc_pkg::CODE_W-1:0]               rsp_time_code,
   output logic [asrc_pkg::PAY_W-1:0]                rsp_payload,
   output logic                                      rsp_last_record,
   input  wire logic                                 csr_write_enable,
   input  wire logic [asrc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [asrc_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int unsigned DW = TIMESTAMP_BITS;
   localparam int unsigned CW = (DW > asrc_pkg::TIME_W) ? DW : asrc_pkg::TIME_W;

   // tick difference modulo 2^TIMESTAMP_BITS
   function automatic logic [DW-1:0] tdelta(input logic [asrc_pkg::TIME_W-1:0] later,
                                            input logic [asrc_pkg::TIME_W-1:0] earlier);
      logic [CW-1:0] d;
      d = CW'(later) - CW'(earlier);
      return DW'(d);
   endfunction

   // configuration
   logic [asrc_pkg::KIND_W-1:0]  chip_kind_ff;
   logic [asrc_pkg::SHIFT_W-1:0] shift_ff;
   logic [asrc_pkg::TIME_W-1:0]  xfer_limit_ff;
   logic [asrc_pkg::TIME_W-1:0]  latch_limit_ff;

   // held item
   logic                          item_valid_ff, item_valid_in;
   logic [asrc_pkg::MISS_W-1:0]   cnt_ff, cnt_in;
   logic [asrc_pkg::WIN_W-1:0]    win_ff;
   logic [asrc_pkg::TIME_W-1:0]   sched_ff;
   logic [asrc_pkg::TIME_W-1:0]   start_ff;
   logic [asrc_pkg::TIME_W-1:0]   end_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   asrc_pkg::record_type          rsp_rec_ff, rsp_rec_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          accept;
   logic                          kind_ok;
   asrc_pkg::wbyte_type           b [asrc_pkg::WIN_BYTES];
   asrc_pkg::wbyte_type           crc_1d;
   asrc_pkg::wbyte_type           crc_07;
   logic [DW-1:0]                 xfer_dt;
   logic [DW-1:0]                 age_dt;
   logic [DW-1:0]                 off_dt;
   logic [DW-1:0]                 rnd_add;
   logic [DW-1:0]                 shifted;
   logic [asrc_pkg::TIME_W-1:0]   off_when;
   logic                          slow;
   logic                          aged;
   logic                          late;
   logic [asrc_pkg::PAY_W-1:0]    angle;
   asrc_pkg::record_type          data_rec;
   asrc_pkg::record_type          final_rec;

   assign busy    = item_valid_ff && (cnt_ff != '0);
   assign accept  = start && !busy;
   assign kind_ok = chip_kind_ff <= asrc_pkg::KIND_CRC_07;

   always_comb begin
      for (int k = 0; k < asrc_pkg::WIN_BYTES; k++) begin
         b[k] = win_ff[8*k +: 8];
      end
   end

   always_comb begin
      crc_1d = asrc_pkg::INIT_1D;
      for (int k = 0; k < 6; k++) begin
         crc_1d = asrc_pkg::crc8_byte(crc_1d, b[k], asrc_pkg::POLY_1D);
      end
      crc_07 = asrc_pkg::INIT_07;
      for (int k = 2; k < 5; k++) begin
         crc_07 = asrc_pkg::crc8_byte(crc_07, b[k], asrc_pkg::POLY_07);
      end
   end

   // timing
   assign xfer_dt  = tdelta(end_ff, start_ff);
   assign age_dt   = tdelta(start_ff, sched_ff);
   assign slow     = CW'(xfer_dt) > CW'(xfer_limit_ff);
   assign aged     = CW'(age_dt) > CW'(latch_limit_ff);
   assign off_when = (chip_kind_ff == asrc_pkg::KIND_FLAG_BIT) ? start_ff : end_ff;
   assign off_dt   = tdelta(off_when, sched_ff);
   assign rnd_add  = (shift_ff == '0) ? '0 : DW'(CW'(1) << (shift_ff - 5'd1));
   assign shifted  = (off_dt + rnd_add) >> shift_ff;
   assign late     = shifted >= DW'(asrc_pkg::ERR_CODE);

   always_comb begin
      unique case (chip_kind_ff)
         asrc_pkg::KIND_PARITY_A: angle = {b[0][5:0], b[1], 2'b00};
         asrc_pkg::KIND_PARITY_B: angle = {b[1], b[2][7:2], 2'b00};
         asrc_pkg::KIND_CRC_07:   angle = {b[2], b[3]};
         default:                 angle = {b[0][6:0], b[1], 1'b0};
      endcase
      data_rec = late ? '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_SCHEDULE}
                      : '{shifted[asrc_pkg::CODE_W-1:0], angle};
   end

   always_comb begin
      final_rec = data_rec;
      unique case (chip_kind_ff)
         asrc_pkg::KIND_FLAG_BIT: begin
            if (slow) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_XFER_TIME};
            else if (b[0][7]) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_CRC};
         end
         asrc_pkg::KIND_PARITY_A: begin
            if (slow) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_XFER_TIME};
            else if (^(b[0] ^ b[1])) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_CRC};
            else if (b[0][6]) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_NO_ANGLE};
         end
         asrc_pkg::KIND_CRC_1D: begin
            if (~crc_1d != b[7]) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_CRC};
            else if (!b[6][4]) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_NO_ANGLE};
            else if (!b[0][7]) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_DUP};
            else if (aged) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_SCHEDULE};
            else final_rec = '{{2'b00, b[4][6:1]}, {b[0][6:0], b[1], 1'b0}};
         end
         asrc_pkg::KIND_PARITY_B: begin
            if (slow) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_XFER_TIME};
            else if (^(b[1] ^ b[2])) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_CRC};
            else if (b[2][1]) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_NO_ANGLE};
         end
         asrc_pkg::KIND_CRC_07: begin
            if (slow) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_XFER_TIME};
            else if (crc_07 != b[5]) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_CRC};
            else if (b[4][1]) final_rec = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_NO_ANGLE};
         end
         default: final_rec = data_rec;
      endcase
   end

   // sequencing: overflow records first, then the checked record
   always_comb begin
      item_valid_in = item_valid_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_rec_in    = final_rec;
      rsp_last_in   = 1'b1;
      if (item_valid_ff) begin
         if (cnt_ff != '0) begin
            rsp_valid_in = 1'b1;
            rsp_rec_in   = '{asrc_pkg::ERR_CODE, asrc_pkg::ERR_OVERFLOW};
            rsp_last_in  = (cnt_ff == asrc_pkg::MISS_W'(1)) && !kind_ok;
            cnt_in       = cnt_ff - asrc_pkg::MISS_W'(1);
         end else begin
            rsp_valid_in  = kind_ok;
            item_valid_in = 1'b0;
         end
      end
      if (accept) begin
         item_valid_in = 1'b1;
         cnt_in        = req_missed_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff   <= req_response_window;
         sched_ff <= req_scheduled_time;
         start_ff <= req_start_time;
         end_ff   <= req_end_time;
      end
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_kind_ff   <= '0;
         shift_ff       <= '0;
         xfer_limit_ff  <= asrc_pkg::XFER_LIMIT_RST;
         latch_limit_ff <= asrc_pkg::LATCH_AGE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            asrc_pkg::CSR_CHIP_KIND:     chip_kind_ff   <= csr_write_data[asrc_pkg::KIND_W-1:0];
            asrc_pkg::CSR_SHIFT_AMOUNT:  shift_ff       <= csr_write_data[asrc_pkg::SHIFT_W-1:0];
            asrc_pkg::CSR_XFER_LIMIT:    xfer_limit_ff  <= csr_write_data[asrc_pkg::TIME_W-1:0];
            asrc_pkg::CSR_LATCH_AGE_LIM: latch_limit_ff <= csr_write_data[asrc_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_time_code   = rsp_rec_ff.time_code;
   assign rsp_payload     = rsp_rec_ff.payload;
   assign rsp_last_record = rsp_last_ff;

   // pending overflow gives an overflow record next cycle
   `ASRC_ASSERT_NXT(a_overflow_rec, clock, reset, item_valid_ff && (cnt_ff != '0), rsp_valid && (rsp_time_code == asrc_pkg::ERR_CODE) && (rsp_payload == asrc_pkg::ERR_OVERFLOW))
   // a record that is not the last is always followed by another
   `ASRC_ASSERT_NXT(a_no_gap, clock, reset, rsp_valid && !rsp_last_record, rsp_valid)
   // item without missed ticks yields its single record via the held item and the result register
   `ASRC_ASSERT_DLY2(a_latency, clock, reset, accept && (req_missed_ticks == '0) && kind_ok, rsp_valid && rsp_last_record)

endmodule

`default_nettype wire

@@ dv/tb_angle_sensor_response_checker.sv @@
// Testbench for the angle sensor response checker: directed and random items against a predictor.
`timescale 1ns / 100ps

module tb_angle_sensor_response_checker;
   import asrc_pkg::*;

   localparam int unsigned RESET_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned BATCHES      = 5;
   localparam int unsigned BATCH_ITEMS  = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_LATCH_AGE_LIM + 3'd1;
   localparam logic [KIND_W-1:0]    KIND_FIRST_UNUSED = KIND_CRC_07 + 3'd1;
   localparam logic [KIND_W-1:0]    KIND_LAST_UNUSED  = {KIND_W{1'b1}};

   typedef struct packed {
      logic [WIN_W-1:0]  window;
      logic [TIME_W-1:0] sched_tick;
      logic [TIME_W-1:0] start_tick;
      logic [TIME_W-1:0] end_tick;
      logic [MISS_W-1:0] missed;
   } sensor_item_t;

   typedef struct packed {
      logic [CODE_W-1:0] time_code;
      logic [PAY_W-1:0]  payload;
      logic              last_record;
   } sensor_record_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [WIN_W-1:0]  req_response_window = '0;
   logic [TIME_W-1:0] req_scheduled_time  = '0;
   logic [TIME_W-1:0] req_start_time      = '0;
   logic [TIME_W-1:0] req_end_time        = '0;
   logic [MISS_W-1:0] req_missed_ticks    = '0;
   logic              rsp_valid;
   logic [CODE_W-1:0] rsp_time_code;
   logic [PAY_W-1:0]  rsp_payload;
   logic              rsp_last_record;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   logic [KIND_W-1:0]  cfg_kind       = KIND_FLAG_BIT;
   logic [SHIFT_W-1:0] cfg_shift      = '0;
   logic [TIME_W-1:0]  cfg_xfer_limit = XFER_LIMIT_RST;
   logic [TIME_W-1:0]  cfg_age_limit  = LATCH_AGE_RST;

   sensor_record_t expected_records[$];
   int unsigned    fail_count = 0;
   int unsigned    idle_pct   = 0;

   angle_sensor_response_checker DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_response_window (req_response_window),
      .req_scheduled_time  (req_scheduled_time),
      .req_start_time      (req_start_time),
      .req_end_time        (req_end_time),
      .req_missed_ticks    (req_missed_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_time_code       (rsp_time_code),
      .rsp_payload         (rsp_payload),
      .rsp_last_record     (rsp_last_record),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // MSB-first CRC8 over count window bytes from byte first.
   function automatic logic [7:0] crc8_window(logic [WIN_W-1:0] w, int first, int count,
                                              logic [7:0] seed, logic [7:0] poly);
      logic [7:0] c;
      c = seed;
      for (int k = first; k < first + count; k++) begin
         c = c ^ w[8*k +: 8];
         for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Status bits set so that an angle is reported.
   function automatic logic [WIN_W-1:0] set_flags(logic [KIND_W-1:0] kind, logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] r;
      r = w;
      case (kind)
         KIND_FLAG_BIT: r[7] = 1'b0;
         KIND_PARITY_A: r[6] = 1'b0;
         KIND_CRC_1D: begin
            r[52] = 1'b1;
            r[7]  = 1'b1;
         end
         KIND_PARITY_B: r[17] = 1'b0;
         KIND_CRC_07:   r[33] = 1'b0;
         default: ;
      endcase
      return r;
   endfunction

   // Parity or CRC byte made consistent with the rest of the window.
   function automatic logic [WIN_W-1:0] fix_check(logic [KIND_W-1:0] kind, logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] r;
      r = w;
      case (kind)
         KIND_PARITY_A: if (^r[15:0]) r[8] = ~r[8];
         KIND_CRC_1D:   r[63:56] = ~crc8_window(r, 0, 6, INIT_1D, POLY_1D);
         KIND_PARITY_B: if (^r[23:8]) r[16] = ~r[16];
         KIND_CRC_07:   r[47:40] = crc8_window(r, 2, 3, INIT_07, POLY_07);
         default: ;
      endcase
      return r;
   endfunction

   function automatic sensor_item_t item_of(logic [WIN_W-1:0] w, logic [TIME_W-1:0] sched,
                                            logic [TIME_W-1:0] st, logic [TIME_W-1:0] en,
                                            logic [MISS_W-1:0] missed);
      sensor_item_t it;
      it.window     = w;
      it.sched_tick = sched;
      it.start_tick = st;
      it.end_tick   = en;
      it.missed     = missed;
      return it;
   endfunction

   // Queues the overflow records and, for a used chip kind, the decoded record of one transfer.
   function automatic void predict_records(sensor_item_t it);
      sensor_record_t rec;
      logic [7:0]        b [WIN_BYTES];
      logic [7:0]        crc;
      logic [TIME_W-1:0] offset;
      logic [TIME_W-1:0] when_tick;
      logic [PAY_W-1:0]  angle;
      logic              slow;
      logic              has_main;
      logic              good;
      for (int k = 0; k < WIN_BYTES; k++) b[k] = it.window[8*k +: 8];
      slow      = (it.end_tick - it.start_tick) > cfg_xfer_limit;
      has_main  = 1'b1;
      good      = 1'b0;
      when_tick = it.end_tick;
      angle     = '0;
      rec.time_code   = ERR_CODE;
      rec.payload     = ERR_OVERFLOW;
      rec.last_record = 1'b1;
      case (cfg_kind)
         KIND_FLAG_BIT: begin
            if (slow) rec.payload = ERR_XFER_TIME;
            else if (b[0][7]) rec.payload = ERR_CRC;
            else begin
               good      = 1'b1;
               when_tick = it.start_tick;
               angle     = {b[0][6:0], b[1], 1'b0};
            end
         end
         KIND_PARITY_A: begin
            if (slow) rec.payload = ERR_XFER_TIME;
            else if (^(b[0] ^ b[1])) rec.payload = ERR_CRC;
            else if (b[0][6]) rec.payload = ERR_NO_ANGLE;
            else begin
               good  = 1'b1;
               angle = {b[0][5:0], b[1], 2'b00};
            end
         end
         KIND_CRC_1D: begin
            crc    = ~crc8_window(it.window, 0, 6, INIT_1D, POLY_1D);
            offset = it.start_tick - it.sched_tick;
            if (crc != b[7]) rec.payload = ERR_CRC;
            else if (!b[6][4]) rec.payload = ERR_NO_ANGLE;
            else if (!b[0][7]) rec.payload = ERR_DUP;
            else if (offset > cfg_age_limit) rec.payload = ERR_SCHEDULE;
            else begin
               rec.time_code = {2'b00, b[4][6:1]};
               rec.payload   = {b[0][6:0], b[1], 1'b0};
            end
         end
         KIND_PARITY_B: begin
            if (slow) rec.payload = ERR_XFER_TIME;
            else if (^(b[1] ^ b[2])) rec.payload = ERR_CRC;
            else if (b[2][1]) rec.payload = ERR_NO_ANGLE;
            else begin
               good  = 1'b1;
               angle = {b[1], b[2][7:2], 2'b00};
            end
         end
         KIND_CRC_07: begin
            crc = crc8_window(it.window, 2, 3, INIT_07, POLY_07);
            if (slow) rec.payload = ERR_XFER_TIME;
            else if (crc != b[5]) rec.payload = ERR_CRC;
            else if (b[4][1]) rec.payload = ERR_NO_ANGLE;
            else begin
               good  = 1'b1;
               angle = {b[2], b[3]};
            end
         end
         default: has_main = 1'b0;
      endcase
      if (good) begin
         offset = when_tick - it.sched_tick;
         if (cfg_shift != 0)
            offset = (offset + (32'd1 << (cfg_shift - 5'd1))) >> cfg_shift;
         if (offset >= 32'(ERR_CODE)) begin
            rec.payload = ERR_SCHEDULE;
         end else begin
            rec.time_code = offset[CODE_W-1:0];
            rec.payload   = angle;
         end
      end
      for (int k = 0; k < it.missed; k++) begin
         expected_records.push_back({ERR_CODE, ERR_OVERFLOW,
                                     1'(k == it.missed - 1 && !has_main)});
      end
      if (has_main) expected_records.push_back(rec);
   endfunction

   function automatic sensor_item_t random_item();
      sensor_item_t it;
      logic [WIN_W-1:0]  w;
      logic [63:0]       span;
      logic [TIME_W-1:0] offset;
      logic [TIME_W-1:0] xfer;
      logic [TIME_W-1:0] age;
      int unsigned       pick;
      int unsigned       flip;
      w = {$urandom, $urandom};
      if ($urandom_range(99) < 85) w = set_flags(cfg_kind, w);
      if ($urandom_range(99) < 85) w = fix_check(cfg_kind, w);
      if ($urandom_range(99) < 8) begin
         flip    = $urandom_range(WIN_W - 1);
         w[flip] = ~w[flip];
      end
      it.window = w;
      pick = $urandom_range(99);
      it.missed = (pick < 70) ? '0 : (pick < 95) ? MISS_W'($urandom_range(4, 1))
                                                 : MISS_W'($urandom_range(63, 5));
      span = 64'd256 << cfg_shift;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      offset = ($urandom_range(99) < 85) ? $urandom_range(span[31:0], 0) : $urandom;
      pick = $urandom_range(99);
      xfer = (pick < 80) ? $urandom_range(cfg_xfer_limit, 0)
                         : (pick < 90) ? cfg_xfer_limit + 32'd1 : $urandom;
      pick = $urandom_range(99);
      age  = (pick < 80) ? $urandom_range(cfg_age_limit, 0)
                         : (pick < 90) ? cfg_age_limit + 32'd1 : $urandom;
      it.sched_tick = $urandom;
      if (cfg_kind == KIND_FLAG_BIT) begin
         it.start_tick = it.sched_tick + offset;
         it.end_tick   = it.start_tick + xfer;
      end else if (cfg_kind == KIND_CRC_1D) begin
         it.start_tick = it.sched_tick + age;
         it.end_tick   = $urandom;
      end else begin
         it.end_tick   = it.sched_tick + offset;
         it.start_tick = it.end_tick - xfer;
      end
      return it;
   endfunction

   // Called at a rising edge; returns at the edge that takes the item.
   task automatic send_item(sensor_item_t it);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_response_window <= it.window;
      req_scheduled_time  <= it.sched_tick;
      req_start_time      <= it.start_tick;
      req_end_time        <= it.end_tick;
      req_missed_ticks    <= it.missed;
      do @(posedge clock); while (busy);
      predict_records(it);
   endtask

   task automatic go_idle();
      start <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_CHIP_KIND:     cfg_kind       = data[KIND_W-1:0];
         CSR_SHIFT_AMOUNT:  cfg_shift      = data[SHIFT_W-1:0];
         CSR_XFER_LIMIT:    cfg_xfer_limit = data[TIME_W-1:0];
         CSR_LATCH_AGE_LIM: cfg_age_limit  = data[TIME_W-1:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Narrow registers get random upper data bits, which must be ignored.
   task automatic set_config(logic [KIND_W-1:0] kind, logic [SHIFT_W-1:0] shift,
                             logic [TIME_W-1:0] xfer_limit, logic [TIME_W-1:0] age_limit);
      logic [CSR_DATA_W-1:0] d;
      go_idle();
      d = $urandom;
      d[KIND_W-1:0] = kind;
      write_csr(CSR_CHIP_KIND, d);
      d = $urandom;
      d[SHIFT_W-1:0] = shift;
      write_csr(CSR_SHIFT_AMOUNT, d);
      write_csr(CSR_XFER_LIMIT, xfer_limit);
      write_csr(CSR_LATCH_AGE_LIM, age_limit);
   endtask

   task automatic test_defaults();
      send_item(item_of('0, '0, '0, '0, '0));
      send_item(item_of('1, '1, '1, '1, '1));
      send_item(item_of(64'h3F7F, 32'd100, 32'd100, 32'd3701, 6'd0));
      send_item(item_of(64'hAA55, 32'hFFFF_FFF0, 32'h10, 32'h10 + 32'd3600, 6'd2));
      send_item(item_of(64'h1234, 32'd1000, 32'd1255, 32'd1260, 6'd0));
      send_item(item_of(64'h1234, 32'd1000, 32'd1254, 32'd1260, 6'd0));
   endtask

   task automatic test_each_kind();
      logic [WIN_W-1:0] good;
      set_config(KIND_PARITY_A, 5'd0, XFER_LIMIT_RST, LATCH_AGE_RST);
      good = fix_check(KIND_PARITY_A, set_flags(KIND_PARITY_A, 64'h0123_4567_89AB_CDEF));
      send_item(item_of(good, 32'd0, 32'd10, 32'd87, 6'd0));
      send_item(item_of(good ^ 64'h100, 32'd0, 32'd10, 32'd87, 6'd0));
      send_item(item_of(fix_check(KIND_PARITY_A, good | 64'h40), 32'd0, 32'd10, 32'd87, 6'd0));
      send_item(item_of(good, 32'd0, 32'd10, 32'd3611, 6'd1));

      set_config(KIND_CRC_1D, 5'd0, XFER_LIMIT_RST, 32'd1000);
      good = fix_check(KIND_CRC_1D, set_flags(KIND_CRC_1D, 64'hFEDC_BA98_7654_3210));
      send_item(item_of(good, 32'd500, 32'd1500, 32'hFFFF_0000, 6'd0));
      send_item(item_of(good ^ (64'h1 << 56), 32'd500, 32'd1500, 32'd1600, 6'd0));
      send_item(item_of(fix_check(KIND_CRC_1D, good & ~(64'h1 << 52)),
                        32'd500, 32'd1500, 32'd1600, 6'd0));
      send_item(item_of(fix_check(KIND_CRC_1D, good & ~64'h80), 32'd500, 32'd1500, 32'd1600,
                        6'd0));
      send_item(item_of(good, 32'd500, 32'd1501, 32'd1600, 6'd0));

      // zero transfer limit: any non-zero transfer time is too slow
      set_config(KIND_PARITY_B, 5'd1, 32'd0, LATCH_AGE_RST);
      good = fix_check(KIND_PARITY_B, set_flags(KIND_PARITY_B, 64'h0F1E_2D3C_4B5A_6978));
      send_item(item_of(good, 32'h100, 32'h22C, 32'h22C, 6'd0));
      send_item(item_of(good ^ (64'h1 << 16), 32'h100, 32'h22C, 32'h22C, 6'd0));
      send_item(item_of(fix_check(KIND_PARITY_B, good | (64'h1 << 17)),
                        32'h100, 32'h22C, 32'h22C, 6'd0));
      send_item(item_of(good, 32'h100, 32'h22C, 32'h22D, 6'd0));

      // full shift: the rounding addition wraps
      set_config(KIND_CRC_07, 5'd31, 32'hFFFF_FFFE, LATCH_AGE_RST);
      good = fix_check(KIND_CRC_07, set_flags(KIND_CRC_07, 64'h5A5A_C3C3_3C3C_A5A5));
      send_item(item_of(good, 32'd0, 32'hBFFF_FFFB, 32'hC000_0000, 6'd0));
      send_item(item_of(good, 32'd0, 32'h7FFF_FFFB, 32'h8000_0000, 6'd0));
      send_item(item_of(good ^ (64'h1 << 40), 32'd0, 32'd5, 32'd9, 6'd0));
      send_item(item_of(fix_check(KIND_CRC_07, good | (64'h1 << 33)), 32'd0, 32'd5, 32'd9,
                        6'd0));
      send_item(item_of(good, 32'd0, 32'd0, 32'hFFFF_FFFF, 6'd0));
   endtask

   task automatic test_unused_kind_and_index();
      set_config(KIND_FIRST_UNUSED, 5'd0, XFER_LIMIT_RST, LATCH_AGE_RST);
      send_item(item_of({$urandom, $urandom}, $urandom, $urandom, $urandom, 6'd0));
      send_item(item_of({$urandom, $urandom}, $urandom, $urandom, $urandom, 6'd2));
      go_idle();
      write_csr(CSR_CHIP_KIND, 32'(KIND_LAST_UNUSED));
      send_item(item_of({$urandom, $urandom}, $urandom, $urandom, $urandom, 6'd1));
      go_idle();
      for (int i = 0; i < 4; i++) write_csr(CSR_IDX_W'(CSR_FIRST_UNUSED + i), $urandom);
      write_csr(CSR_CHIP_KIND, 32'(KIND_FLAG_BIT));
      send_item(item_of(64'h1234, 32'd0, 32'd40, 32'd3640, 6'd0));
   endtask

   task automatic test_random_traffic();
      int unsigned        phase_pct [3] = '{10, 87, 0};
      logic [KIND_W-1:0]  kind;
      logic [SHIFT_W-1:0] shift;
      logic [TIME_W-1:0]  xfer_limit;
      logic [TIME_W-1:0]  age_limit;
      for (int phase = 0; phase < 3; phase++) begin
         for (int batch = 0; batch < BATCHES; batch++) begin
            idle_pct = 0;
            kind = ($urandom_range(9) < 8) ? KIND_W'($urandom_range(KIND_CRC_07, KIND_FLAG_BIT))
                                           : KIND_W'($urandom_range(KIND_LAST_UNUSED,
                                                                    KIND_FIRST_UNUSED));
            case ($urandom_range(3))
               0:       shift = '0;
               1:       shift = '1;
               2:       shift = SHIFT_W'($urandom_range(4));
               default: shift = SHIFT_W'($urandom);
            endcase
            case ($urandom_range(3))
               0:       xfer_limit = '0;
               1:       xfer_limit = '1;
               2:       xfer_limit = XFER_LIMIT_RST;
               default: xfer_limit = $urandom_range(5000);
            endcase
            case ($urandom_range(3))
               0:       age_limit = '0;
               1:       age_limit = '1;
               2:       age_limit = LATCH_AGE_RST;
               default: age_limit = $urandom_range(200000);
            endcase
            set_config(kind, shift, xfer_limit, age_limit);
            if ($urandom_range(4) == 0)
               write_csr(CSR_IDX_W'($urandom_range(CSR_IDX_W'('1), CSR_FIRST_UNUSED)), $urandom);
            idle_pct = phase_pct[phase];
            for (int n = 0; n < BATCH_ITEMS; n++) send_item(random_item());
         end
      end
   endtask

   always @(posedge clock) begin : check_records
      sensor_record_t want;
      if (!reset && rsp_valid) begin
         if (expected_records.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected record: code %0d payload 0x%04h last %0b",
                        rsp_time_code, rsp_payload, rsp_last_record);
         end else begin
            want = expected_records.pop_front();
            if (rsp_time_code !== want.time_code || rsp_payload !== want.payload ||
                rsp_last_record !== want.last_record) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("record mismatch: expected code %0d payload 0x%04h last %0b, got code %0d payload 0x%04h last %0b",
                           want.time_code, want.payload, want.last_record,
                           rsp_time_code, rsp_payload, rsp_last_record);
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_each_kind();
      test_unused_kind_and_index();
      test_random_traffic();
      go_idle();
      if (fail_count == 0 && expected_records.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ angle_sensor_response_checker.f @@
+incdir+src
src/asrc_pkg.sv
src/angle_sensor_response_checker.sv
dv/tb_angle_sensor_response_checker.sv
